>>> src/assert_macros.svh
// Assertion helper macros shared by the RTL files of the terrain height query block.
// Each macro expands to one labeled concurrent assertion clocked by clk, reset by arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/htq_pkg.sv
// Package for the terrain height query block: payload structs, register indexes and
// controller command and status types. Depends on nothing.
`default_nettype none
package htq_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 32;

	typedef enum logic [CfgIdxW-1:0] {
		REG_CELLS_X   = 3'd0,
		REG_CELLS_Z   = 3'd1,
		REG_SPACING_X = 3'd2,
		REG_SPACING_Z = 3'd3,
		REG_ORIGIN_X  = 3'd4,
		REG_ORIGIN_Y  = 3'd5,
		REG_ORIGIN_Z  = 3'd6
	} reg_idx_t;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [6:0]         grid_x;
		logic [6:0]         grid_z;
		logic signed [31:0] height_value;
		logic signed [31:0] query_x;
		logic signed [31:0] query_y;
		logic signed [31:0] query_z;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] ground_height;
		logic               outside;
	} out_beat_t;

	// Datapath operations selected by the controller.
	typedef enum logic [3:0] {
		OP_NONE    = 4'd0,
		OP_LOAD    = 4'd1,
		OP_BOUNDS  = 4'd2,
		OP_DIVINIT = 4'd3,
		OP_DIVSTEP = 4'd4,
		OP_CELL    = 4'd5,
		OP_READ    = 4'd6,
		OP_TRI     = 4'd7,
		OP_TERMS   = 4'd8,
		OP_SUM     = 4'd9
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] sel;
	} dp_cmd_t;

	typedef struct packed {
		logic is_query;
		logic outside;
		logic div_done;
	} dp_stat_t;

endpackage
`default_nettype wire

>>> src/heightmap_triangle_height_query.sv
// Terrain height query block: stores vertex heights of a grid and answers height
// queries by triangle interpolation. Channel in: in_valid/in_stall with payload in_data.
// Channel out: out_valid/out_stall with payload out_data. A write item stores one height
// as it is accepted and gives no beat; the next item is taken after its decode state.
// A query outside the terrain skips the divisions and goes on to the summing step.
// An inside query waits on the shared divider, which runs its four divisions one after
// another (two for the cell index, two for the slope terms), one quotient bit at a time.
// One item is in work at a time; a new item is taken in the cycle after the result beat
// leaves. The height store powers up undefined; reads of vertices never written return
// garbage. Reset clears configuration to one unit cell, unit spacing and zero origin.
// While the receiver stalls, the result beat holds and no new input beat is taken.
// Configuration writes via cfg_we/cfg_index/cfg_data take effect at once; the user must
// make them only while idle, as the block does not enforce this.
// Depends on htq_pkg, htq_ctrl, htq_datapath.
`default_nettype none
module heightmap_triangle_height_query #(
	parameter int unsigned MAX_CELLS_X = 64,
	parameter int unsigned MAX_CELLS_Z = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [htq_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [htq_pkg::CfgDataW-1:0] cfg_data,
	input  wire logic                         in_valid,
	output      logic                         in_stall,
	input  wire htq_pkg::in_beat_t            in_data,
	output      logic                         out_valid,
	input  wire logic                         out_stall,
	output      htq_pkg::out_beat_t           out_data
);

	htq_pkg::dp_cmd_t  cmd;
	htq_pkg::dp_stat_t stat;

	htq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
	);

	htq_datapath #(.MaxCellsX(MAX_CELLS_X), .MaxCellsZ(MAX_CELLS_Z)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_beat(in_data), .cmd(cmd), .stat(stat),
		.out_beat(out_data)
	);

endmodule
`default_nettype wire

>>> src/htq_ram.sv
// Generic single-port RAM with a registered read for the terrain height query block.
// Stands alone; depends on no package.
`default_nettype none
module htq_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 4225
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output      logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	// One access per cycle; the read data is registered.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

>>> src/htq_divider.sv
// Restoring divider, one quotient bit per cycle, shared by the height query datapath.
// Depends on nothing but its ports.
`default_nettype none
module htq_divider #(
	parameter int unsigned NumW = 64,
	parameter int unsigned DenW = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [NumW-1:0] num,
	input  wire logic [DenW-1:0] den,
	output      logic [NumW-1:0] quot,
	output      logic [DenW-1:0] rem,
	output      logic            done
);

	localparam int unsigned CntW = $clog2(NumW + 1);

	logic [NumW-1:0] quot_q;
	logic [DenW:0]   rem_q;
	logic [DenW-1:0] den_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic [DenW:0]   trial;

	assign trial = {rem_q[DenW-1:0], quot_q[NumW-1]};

	// Shift one numerator bit into the partial remainder each cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CntW'(NumW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CntW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q  <= trial - {1'b0, den_q};
				quot_q <= {quot_q[NumW-2:0], 1'b1};
			end else begin
				rem_q  <= trial;
				quot_q <= {quot_q[NumW-2:0], 1'b0};
			end
		end
	end

	assign quot = quot_q;
	assign rem  = rem_q[DenW-1:0];
	assign done = !busy_q && !start;

endmodule
`default_nettype wire

>>> src/htq_datapath.sv
// Datapath of the terrain height query: registers, height store, bounds test,
// cell search, triangle choice and slope terms. Depends on htq_pkg, htq_ram, htq_divider.
`default_nettype none
`include "assert_macros.svh"
module htq_datapath #(
	parameter int unsigned MaxCellsX = 64,
	parameter int unsigned MaxCellsZ = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [htq_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [htq_pkg::CfgDataW-1:0] cfg_data,
	input  wire htq_pkg::in_beat_t          in_beat,
	input  wire htq_pkg::dp_cmd_t           cmd,
	output      htq_pkg::dp_stat_t          stat,
	output      htq_pkg::out_beat_t         out_beat
);

	localparam int unsigned StrideZ = MaxCellsZ + 1;
	localparam int unsigned Depth   = (MaxCellsX + 1) * StrideZ;
	localparam int unsigned AddrW   = $clog2(Depth);
	localparam int unsigned CxW     = $clog2(MaxCellsX + 1);
	localparam int unsigned CzW     = $clog2(MaxCellsZ + 1);

	// Configuration registers.
	logic [6:0]         cells_x_q, cells_z_q;
	logic [30:0]        spacing_x_q, spacing_z_q;
	logic signed [31:0] origin_x_q, origin_y_q, origin_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_x_q   <= 7'd1;
			cells_z_q   <= 7'd1;
			spacing_x_q <= 31'd65536;
			spacing_z_q <= 31'd65536;
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			origin_z_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				htq_pkg::REG_CELLS_X:   cells_x_q   <= cfg_data[6:0];
				htq_pkg::REG_CELLS_Z:   cells_z_q   <= cfg_data[6:0];
				htq_pkg::REG_SPACING_X: spacing_x_q <= cfg_data[30:0];
				htq_pkg::REG_SPACING_Z: spacing_z_q <= cfg_data[30:0];
				htq_pkg::REG_ORIGIN_X:  origin_x_q  <= cfg_data;
				htq_pkg::REG_ORIGIN_Y:  origin_y_q  <= cfg_data;
				htq_pkg::REG_ORIGIN_Z:  origin_z_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Captured item.
	htq_pkg::in_beat_t item_q;
	logic [6:0] cx_q, cz_q;
	logic signed [32:0] dx_q, dz_q;
	logic outside_q;
	logic [CxW-1:0] i_q;
	logic [CzW-1:0] j_q;
	logic [31:0] fx_q, fz_q;
	logic signed [31:0] ha_q, hb_q, hc_q, hd_q;
	logic upper_q;
	logic signed [33:0] acc_q;
	logic signed [31:0] res_q;
	logic [62:0] prodx_q, prodz_q;

	// Clamped cell counts.
	logic [6:0] cx_c, cz_c;
	assign cx_c = ({25'd0, cells_x_q} > 32'(MaxCellsX)) ? 7'(MaxCellsX) : cells_x_q;
	assign cz_c = ({25'd0, cells_z_q} > 32'(MaxCellsZ)) ? 7'(MaxCellsZ) : cells_z_q;

	// Height store addressing; a write beat goes into the store as it is accepted.
	logic          ram_we;
	logic [AddrW-1:0] ram_addr, wr_addr, rd_addr;
	logic [31:0]   ram_rdata;
	logic [CxW:0]  rx;
	logic [CzW:0]  rz;

	assign wr_addr = AddrW'(32'(in_beat.grid_x) * 32'(StrideZ) + 32'(in_beat.grid_z));
	assign rx = {1'b0, i_q} + {{CxW{1'b0}}, cmd.sel[0]};
	assign rz = {1'b0, j_q} + {{CzW{1'b0}}, cmd.sel[1]};
	assign rd_addr = AddrW'(32'(rx) * 32'(StrideZ) + 32'(rz));
	assign ram_we = (cmd.op == htq_pkg::OP_LOAD) && (in_beat.kind == htq_pkg::KIND_WRITE)
		&& (32'(in_beat.grid_x) <= 32'(MaxCellsX)) && (32'(in_beat.grid_z) <= 32'(MaxCellsZ));
	assign ram_addr = (cmd.op == htq_pkg::OP_LOAD) ? wr_addr : rd_addr;

	htq_ram #(.Width(32), .Depth(Depth)) u_store (
		.clk(clk), .we(ram_we), .addr(ram_addr),
		.wdata(in_beat.height_value), .rdata(ram_rdata)
	);

	// Shared divider: sel 0 divides dx, sel 1 dz; sel 2 and 3 divide slope products.
	logic        div_start;
	logic [63:0] div_num, div_quot;
	logic [31:0] div_den, div_rem;
	logic        div_done;

	always_comb begin
		case (cmd.sel)
			2'd0: begin div_num = 64'(dx_q[31:0]); div_den = {1'b0, spacing_x_q}; end
			2'd1: begin div_num = 64'(dz_q[31:0]); div_den = {1'b0, spacing_z_q}; end
			2'd2: begin div_num = 64'(prodx_q);    div_den = {1'b0, spacing_x_q}; end
			default: begin div_num = 64'(prodz_q); div_den = {1'b0, spacing_z_q}; end
		endcase
	end
	assign div_start = (cmd.op == htq_pkg::OP_DIVINIT);

	htq_divider #(.NumW(64), .DenW(32)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.quot(div_quot), .rem(div_rem), .done(div_done)
	);

	// Slope term operands for the chosen triangle.
	logic signed [32:0] diff_x, diff_z;
	logic [31:0] bx, bz;
	logic signed [32:0] sel_diff;
	logic [31:0] sel_b;
	logic [31:0] abs_diff;
	logic signed [34:0] mag;
	assign diff_x = upper_q ? (33'(hd_q) - 33'(hc_q)) : (33'(hb_q) - 33'(ha_q));
	assign diff_z = upper_q ? (33'(ha_q) - 33'(hc_q)) : (33'(hb_q) - 33'(hd_q));
	assign bx = upper_q ? fx_q : ({1'b0, spacing_x_q} - fx_q);
	assign bz = upper_q ? ({1'b0, spacing_z_q} - fz_q) : fz_q;
	assign sel_diff = cmd.sel[0] ? diff_z : diff_x;
	assign sel_b = cmd.sel[0] ? bz : bx;
	assign abs_diff = sel_diff[32] ? 32'(-sel_diff) : sel_diff[31:0];
	assign mag = sel_diff[32] ? -35'(div_quot[33:0]) : 35'(div_quot[33:0]);

	// Triangle compare products, one multiplier each.
	logic [62:0] tri_l, tri_r;
	assign tri_l = 63'(fx_q) * 63'(spacing_z_q);
	assign tri_r = 63'(fz_q) * 63'(spacing_x_q);

	logic signed [34:0] final_sum;
	assign final_sum = 35'(acc_q) + 35'(origin_y_q);

	always_ff @(posedge clk) begin
		case (cmd.op)
			htq_pkg::OP_LOAD: begin
				item_q <= in_beat;
			end
			htq_pkg::OP_BOUNDS: begin
				cx_q <= cx_c;
				cz_q <= cz_c;
				dx_q <= 33'(item_q.query_x) - 33'(origin_x_q);
				dz_q <= 33'(item_q.query_z) - 33'(origin_z_q);
				// dx ranges over 33 bits; the far edge test uses spacing times count.
				outside_q <= (cx_c == 7'd0) || (cz_c == 7'd0)
					|| (spacing_x_q == 31'd0) || (spacing_z_q == 31'd0);
			end
			htq_pkg::OP_DIVSTEP: begin
				// Bounds resolve here against the product of spacing and count.
				if (cmd.sel == 2'd0) begin
					if (dx_q <= 0 || dz_q <= 0
						|| 64'(dx_q[31:0]) >= 64'(spacing_x_q) * 64'(cx_q)
						|| 64'(dz_q[31:0]) >= 64'(spacing_z_q) * 64'(cz_q)) begin
						outside_q <= 1'b1;
					end
				end
			end
			htq_pkg::OP_CELL: begin
				if (cmd.sel == 2'd0) begin
					if (div_quot > 64'(cx_q - 7'd1)) begin
						i_q  <= CxW'(cx_q - 7'd1);
						fx_q <= 32'(64'(dx_q[31:0]) - 64'(cx_q - 7'd1) * 64'(spacing_x_q));
					end else begin
						i_q  <= CxW'(div_quot);
						fx_q <= div_rem;
					end
				end else if (cmd.sel == 2'd1) begin
					if (div_quot > 64'(cz_q - 7'd1)) begin
						j_q  <= CzW'(cz_q - 7'd1);
						fz_q <= 32'(64'(dz_q[31:0]) - 64'(cz_q - 7'd1) * 64'(spacing_z_q));
					end else begin
						j_q  <= CzW'(div_quot);
						fz_q <= div_rem;
					end
				end else begin
					// The upper triangle adds its slope terms, the lower one subtracts them.
					acc_q <= upper_q ? 34'(35'(acc_q) + mag) : 34'(35'(acc_q) - mag);
				end
			end
			htq_pkg::OP_READ: begin
				case (cmd.sel)
					2'd0: ha_q <= ram_rdata;
					2'd1: hb_q <= ram_rdata;
					2'd2: hc_q <= ram_rdata;
					default: hd_q <= ram_rdata;
				endcase
			end
			htq_pkg::OP_TRI: begin
				upper_q <= tri_l < tri_r;
			end
			htq_pkg::OP_TERMS: begin
				if (cmd.sel[0]) begin
					prodz_q <= 63'(abs_diff) * 63'(sel_b);
				end else begin
					prodx_q <= 63'(abs_diff) * 63'(sel_b);
					acc_q   <= upper_q ? 34'(hc_q) : 34'(hb_q);
				end
			end
			htq_pkg::OP_SUM: begin
				if (outside_q) begin
					res_q <= item_q.query_y;
				end else if (final_sum > 35'sd2147483647) begin
					res_q <= 32'sh7fffffff;
				end else if (final_sum < -35'sd2147483648) begin
					res_q <= 32'sh80000000;
				end else begin
					res_q <= 32'(final_sum);
				end
			end
			default: ;
		endcase
	end

	assign stat.is_query = item_q.kind == htq_pkg::KIND_QUERY;
	assign stat.outside  = outside_q;
	assign stat.div_done = div_done;
	assign out_beat.ground_height = res_q;
	assign out_beat.outside = outside_q;

	`ASSERT_IMPL(a_no_write_on_read, ram_we, cmd.op == htq_pkg::OP_LOAD, "store written outside load")
	`ASSERT_NEXT(a_div_busy, div_start, !div_done, "divider did not start")
	`ASSERT_IMPL(a_read_in_grid, cmd.op == htq_pkg::OP_READ, 32'(rx) <= 32'(MaxCellsX), "read past grid")

endmodule
`default_nettype wire

>>> src/htq_ctrl.sv
// Controller of the terrain height query: sequences load, bounds, divisions, reads,
// triangle choice and the summing step, and runs the handshakes. Depends on htq_pkg.
`default_nettype none
`include "assert_macros.svh"
module htq_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_stall,
	output      logic              out_valid,
	input  wire logic              out_stall,
	input  wire htq_pkg::dp_stat_t stat,
	output      htq_pkg::dp_cmd_t  cmd
);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_DECODE = 12'b000000000010,
		S_BOUND = 12'b000000000100,
		S_DIV   = 12'b000000001000,
		S_WAIT  = 12'b000000010000,
		S_CELL  = 12'b000000100000,
		S_READ  = 12'b000001000000,
		S_RWAIT = 12'b000010000000,
		S_TRI   = 12'b000100000000,
		S_TERM  = 12'b001000000000,
		S_SUM   = 12'b010000000000,
		S_OUT   = 12'b100000000000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] sel_q, sel_d;
	logic [2:0] rd_q, rd_d;
	logic       out_valid_q, out_valid_d;

	// Next state and command decode.
	always_comb begin
		state_d     = state_q;
		sel_d       = sel_q;
		rd_d        = rd_q;
		out_valid_d = out_valid_q;
		cmd.op      = htq_pkg::OP_NONE;
		cmd.sel     = sel_q;
		if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end
		case (state_q)
			S_IDLE: begin
				if (in_valid && !out_valid_q) begin
					cmd.op  = htq_pkg::OP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				// Writes finish here: the store write took place with the load.
				state_d = stat.is_query ? S_BOUND : S_IDLE;
			end
			S_BOUND: begin
				cmd.op  = htq_pkg::OP_BOUNDS;
				sel_d   = 2'd0;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op  = htq_pkg::OP_DIVSTEP;
				cmd.sel = 2'd0;
				if (sel_q == 2'd0 && stat.outside) begin
					state_d = S_SUM;
				end else begin
					state_d = S_WAIT;
				end
			end
			S_WAIT: begin
				cmd.op = htq_pkg::OP_DIVINIT;
				if (stat.outside) begin
					cmd.op  = htq_pkg::OP_NONE;
					state_d = S_SUM;
				end else begin
					state_d = S_CELL;
				end
			end
			S_CELL: begin
				if (stat.div_done) begin
					cmd.op = htq_pkg::OP_CELL;
					case (sel_q)
						2'd0: begin sel_d = 2'd1; state_d = S_WAIT; end
						2'd1: begin rd_d = 3'd0; state_d = S_READ; end
						2'd2: begin sel_d = 2'd3; state_d = S_WAIT; end
						default: state_d = S_SUM;
					endcase
				end
			end
			S_READ: begin
				cmd.sel = rd_q[1:0];
				state_d = S_RWAIT;
			end
			S_RWAIT: begin
				cmd.op  = htq_pkg::OP_READ;
				cmd.sel = rd_q[1:0];
				if (rd_q == 3'd3) begin
					state_d = S_TRI;
				end else begin
					rd_d    = rd_q + 3'd1;
					state_d = S_READ;
				end
			end
			S_TRI: begin
				cmd.op  = htq_pkg::OP_TRI;
				sel_d   = 2'd0;
				state_d = S_TERM;
			end
			S_TERM: begin
				cmd.op  = htq_pkg::OP_TERMS;
				cmd.sel = sel_q;
				if (sel_q == 2'd0) begin
					sel_d = 2'd1;
				end else begin
					sel_d   = 2'd2;
					state_d = S_WAIT;
				end
			end
			S_SUM: begin
				cmd.op  = htq_pkg::OP_SUM;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid_d = 1'b1;
				state_d     = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sel_q       <= 2'd0;
			rd_q        <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			sel_q       <= sel_d;
			rd_q        <= rd_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign in_stall  = (state_q != S_IDLE) || out_valid_q;
	assign out_valid = out_valid_q;

	`ASSERT_IMPL(a_onehot, 1'b1, $onehot(state_q), "state register not one-hot")
	`ASSERT_NEXT(a_out_hold, out_valid_q && out_stall, out_valid_q, "result dropped under stall")
	`ASSERT_IMPL(a_no_accept_busy, out_valid_q, in_stall, "input taken while result waits")

endmodule
`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the terrain height query block: directed table, then
// randomized phases with idle gaps, a long output hold-off and a bit-exact height predictor.
// Depends on htq_pkg and heightmap_triangle_height_query.
`timescale 1ns / 100ps
module testbench;

	localparam int MAXC = 64;
	localparam longint CYCLE_LIMIT = 4000000;
	localparam int SETTLE = 300;

	typedef struct {
		htq_pkg::in_beat_t  b;
		bit                 fixed;
		htq_pkg::out_beat_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [htq_pkg::CfgIdxW-1:0] cfg_index;
	logic [htq_pkg::CfgDataW-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	htq_pkg::in_beat_t in_data;
	logic out_valid;
	logic out_stall;
	htq_pkg::out_beat_t out_data;

	// Local copy of the block's configuration and vertex heights.
	logic [6:0] cells_x_r, cells_z_r;
	logic [30:0] spacing_x_r, spacing_z_r;
	logic signed [31:0] origin_x_r, origin_y_r, origin_z_r;
	logic signed [31:0] vertex_h[0:MAXC][0:MAXC];
	bit vertex_set[0:MAXC][0:MAXC];

	htq_pkg::out_beat_t height_q[$];
	stim_row_t directed_rows[$];
	int errors;
	int mismatches;
	int sent;
	longint cycles;
	bit calm;
	bit hold_req;

	heightmap_triangle_height_query dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	// Free-running clock, 4 ns period.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Run watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic longint rand_range(longint lo, longint hi);
		longint unsigned span;
		span = longint'(hi - lo) + 1;
		return lo + longint'({$urandom, $urandom} % span);
	endfunction

	// Magnitude-exact d * b / c truncated toward zero.
	function automatic longint slope_term(longint d, longint b, longint c);
		longint a, q, r, m;
		a = (d < 0) ? -d : d;
		q = a / c;
		r = a % c;
		m = q * b + (r * b) / c;
		return (d < 0) ? -m : m;
	endfunction

	// Finds the cell and offsets of a query; returns 1 when strictly inside the terrain.
	function automatic bit locate_cell(htq_pkg::in_beat_t b, output int ci, output int cj,
			output longint fx, output longint fz);
		longint qx, qz, ox, oz, sx, sz, cx, cz, dx, dz, i, j;
		qx = $signed(b.query_x);
		qz = $signed(b.query_z);
		ox = origin_x_r;
		oz = origin_z_r;
		sx = spacing_x_r;
		sz = spacing_z_r;
		cx = (cells_x_r > MAXC) ? MAXC : cells_x_r;
		cz = (cells_z_r > MAXC) ? MAXC : cells_z_r;
		ci = 0;
		cj = 0;
		fx = 0;
		fz = 0;
		if (qx <= ox || qz <= oz || qx >= ox + sx * cx || qz >= oz + sz * cz)
			return 1'b0;
		dx = qx - ox;
		dz = qz - oz;
		i = dx / sx;
		j = dz / sz;
		if (i > cx - 1) i = cx - 1;
		if (j > cz - 1) j = cz - 1;
		fx = dx - i * sx;
		fz = dz - j * sz;
		ci = int'(i);
		cj = int'(j);
		return 1'b1;
	endfunction

	// Expected beat for one query.
	function automatic htq_pkg::out_beat_t ground_at(htq_pkg::in_beat_t b);
		htq_pkg::out_beat_t r;
		int i, j;
		longint fx, fz, sx, sz, ha, hb, hc, hd, h;
		if (!locate_cell(b, i, j, fx, fz)) begin
			r.ground_height = b.query_y;
			r.outside = 1'b1;
			return r;
		end
		sx = spacing_x_r;
		sz = spacing_z_r;
		ha = vertex_h[i][j];
		hb = vertex_h[i + 1][j];
		hc = vertex_h[i][j + 1];
		hd = vertex_h[i + 1][j + 1];
		if (fx * sz < fz * sx)
			h = hc + slope_term(hd - hc, fx, sx) + slope_term(ha - hc, sz - fz, sz);
		else
			h = hb - slope_term(hb - ha, sx - fx, sx) - slope_term(hb - hd, fz, sz);
		h = h + origin_y_r;
		if (h > 64'sh7FFFFFFF) h = 64'sh7FFFFFFF;
		if (h < -64'sh80000000) h = -64'sh80000000;
		r.ground_height = h[31:0];
		r.outside = 1'b0;
		return r;
	endfunction

	function automatic htq_pkg::in_beat_t random_beat();
		htq_pkg::in_beat_t b;
		logic [159:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
		b = raw[$bits(htq_pkg::in_beat_t)-1:0];
		return b;
	endfunction

	function automatic htq_pkg::in_beat_t height_beat(int gx, int gz, logic [31:0] h);
		htq_pkg::in_beat_t b;
		b = random_beat();
		b.kind = htq_pkg::KIND_WRITE;
		b.grid_x = gx[6:0];
		b.grid_z = gz[6:0];
		b.height_value = h;
		return b;
	endfunction

	function automatic htq_pkg::in_beat_t query_beat(logic [31:0] x, logic [31:0] y,
			logic [31:0] z);
		htq_pkg::in_beat_t b;
		b = random_beat();
		b.kind = htq_pkg::KIND_QUERY;
		b.query_x = x;
		b.query_y = y;
		b.query_z = z;
		return b;
	endfunction

	function automatic stim_row_t wr_row(int gx, int gz, logic [31:0] h);
		stim_row_t r;
		r.b = height_beat(gx, gz, h);
		r.fixed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic stim_row_t q_row(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			bit fixed);
		stim_row_t r;
		r.b = query_beat(x, y, z);
		r.fixed = fixed;
		r.want.ground_height = y;
		r.want.outside = 1'b1;
		return r;
	endfunction

	// Offers one beat, with random idle cycles first, and returns at its acceptance edge.
	task automatic send_beat(htq_pkg::in_beat_t b);
		if (!calm) begin
			while ($urandom_range(99) < 27) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data <= b;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		sent++;
	endtask

	task automatic store_height(htq_pkg::in_beat_t b);
		if (b.grid_x <= MAXC && b.grid_z <= MAXC) begin
			vertex_h[b.grid_x][b.grid_z] = b.height_value;
			vertex_set[b.grid_x][b.grid_z] = 1'b1;
		end
	endtask

	// Sends one item; a query inside the terrain first gets any unwritten corner heights written.
	task automatic issue(htq_pkg::in_beat_t b, bit fixed, htq_pkg::out_beat_t want);
		int i, j, dx, dz;
		longint fx, fz;
		htq_pkg::in_beat_t w;
		if (b.kind == htq_pkg::KIND_QUERY && locate_cell(b, i, j, fx, fz)) begin
			for (dx = 0; dx < 2; dx++)
				for (dz = 0; dz < 2; dz++)
					if (!vertex_set[i + dx][j + dz]) begin
						w = height_beat(i + dx, j + dz, $urandom);
						send_beat(w);
						store_height(w);
					end
		end
		send_beat(b);
		if (b.kind == htq_pkg::KIND_WRITE)
			store_height(b);
		else
			height_q.push_back(fixed ? want : ground_at(b));
	endtask

	// Waits for every expected beat and lets the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (height_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_reg(htq_pkg::reg_idx_t idx, logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		case (idx)
			htq_pkg::REG_CELLS_X:   cells_x_r = v[6:0];
			htq_pkg::REG_CELLS_Z:   cells_z_r = v[6:0];
			htq_pkg::REG_SPACING_X: spacing_x_r = v[30:0];
			htq_pkg::REG_SPACING_Z: spacing_z_r = v[30:0];
			htq_pkg::REG_ORIGIN_X:  origin_x_r = v;
			htq_pkg::REG_ORIGIN_Y:  origin_y_r = v;
			htq_pkg::REG_ORIGIN_Z:  origin_z_r = v;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic program_terrain(logic [31:0] cx, logic [31:0] cz, logic [31:0] sx,
			logic [31:0] sz, logic [31:0] ox, logic [31:0] oy, logic [31:0] oz);
		set_reg(htq_pkg::REG_CELLS_X, cx);
		set_reg(htq_pkg::REG_CELLS_Z, cz);
		set_reg(htq_pkg::REG_SPACING_X, sx);
		set_reg(htq_pkg::REG_SPACING_Z, sz);
		set_reg(htq_pkg::REG_ORIGIN_X, ox);
		set_reg(htq_pkg::REG_ORIGIN_Y, oy);
		set_reg(htq_pkg::REG_ORIGIN_Z, oz);
		cfg_we <= 1'b0;
	endtask

	// Coordinate strictly inside the span along one axis, sometimes on a grid line.
	function automatic logic [31:0] inside_coord(longint o, longint s, longint c);
		longint lo, hi, k;
		lo = o + 1;
		hi = o + s * c - 1;
		if (lo < -64'sh80000000) lo = -64'sh80000000;
		if (hi > 64'sh7FFFFFFF) hi = 64'sh7FFFFFFF;
		if (lo > hi)
			return $urandom;
		if (c > 1 && $urandom_range(99) < 15) begin
			k = o + s * rand_range(1, c - 1);
			if (k >= lo && k <= hi)
				return k[31:0];
		end
		return 32'(rand_range(lo, hi));
	endfunction

	// One random phase of about n beats, corner writes included: mostly well-formed
	// inside queries, some writes and noise.
	task automatic random_phase(int n);
		int first, pick, cx, cz;
		htq_pkg::in_beat_t b;
		cx = (cells_x_r > MAXC) ? MAXC : cells_x_r;
		cz = (cells_z_r > MAXC) ? MAXC : cells_z_r;
		first = sent;
		while (sent - first < n) begin
			pick = $urandom_range(99);
			if (pick < 65) begin
				b = query_beat(inside_coord(origin_x_r, spacing_x_r, cx), $urandom,
					inside_coord(origin_z_r, spacing_z_r, cz));
			end else if (pick < 85) begin
				if ($urandom_range(9) == 0)
					b = height_beat($urandom_range(127), $urandom_range(127), $urandom);
				else
					b = height_beat($urandom_range(MAXC), $urandom_range(MAXC), $urandom);
			end else begin
				b = random_beat();
			end
			issue(b, 1'b0, '0);
		end
	endtask

	// Receiver: random stalls, calm stretches and one long hold-off.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else begin
				out_stall <= calm ? 1'b0 : ($urandom_range(99) < 27);
			end
		end
	end

	// Result checker against the oldest expectation.
	always @(posedge clk) begin
		htq_pkg::out_beat_t exp_b;
		if (arst_n && out_valid && !out_stall) begin
			if (height_q.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: height %h outside %b",
						out_data.ground_height, out_data.outside);
			end else begin
				exp_b = height_q.pop_front();
				if (exp_b.ground_height !== out_data.ground_height ||
						exp_b.outside !== out_data.outside) begin
					errors++;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected height %h outside %b, got %h %b",
							exp_b.ground_height, exp_b.outside,
							out_data.ground_height, out_data.outside);
				end
			end
		end
	end

	// Main stimulus sequence.
	initial begin
		int r, p;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		errors = 0;
		mismatches = 0;
		sent = 0;
		cycles = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		cells_x_r = 7'd1;
		cells_z_r = 7'd1;
		spacing_x_r = 31'h10000;
		spacing_z_r = 31'h10000;
		origin_x_r = '0;
		origin_y_r = '0;
		origin_z_r = '0;
		for (int x = 0; x <= MAXC; x++)
			for (int z = 0; z <= MAXC; z++)
				vertex_set[x][z] = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table over the reset terrain: one unit cell at the origin.
		directed_rows.push_back(wr_row(0, 0, 32'h7FFFFFFF));
		directed_rows.push_back(wr_row(1, 0, 32'h80000000));
		directed_rows.push_back(wr_row(0, 1, 32'h00000000));
		directed_rows.push_back(wr_row(1, 1, 32'h12345678));
		directed_rows.push_back(wr_row(127, 127, 32'hDEADBEEF));
		directed_rows.push_back(wr_row(65, 0, 32'h55555555));
		directed_rows.push_back(wr_row(64, 64, 32'hFFFFFFFF));
		directed_rows.push_back(q_row(32'h0, 32'h7FFFFFFF, 32'h8000, 1'b1));
		directed_rows.push_back(q_row(32'h10000, 32'h80000000, 32'h8000, 1'b1));
		directed_rows.push_back(q_row(32'h8000, 32'h5, 32'h0, 1'b1));
		directed_rows.push_back(q_row(32'h8000, 32'hFFFFFFFB, 32'h10000, 1'b1));
		directed_rows.push_back(q_row(32'h80000000, 32'h1, 32'h80000000, 1'b1));
		directed_rows.push_back(q_row(32'h7FFFFFFF, 32'h2, 32'h7FFFFFFF, 1'b1));
		directed_rows.push_back(q_row(32'h8000, 32'h0, 32'h8000, 1'b0));
		directed_rows.push_back(q_row(32'h4000, 32'h0, 32'hC000, 1'b0));
		directed_rows.push_back(q_row(32'hC000, 32'h0, 32'h4000, 1'b0));
		directed_rows.push_back(q_row(32'h1, 32'h0, 32'h1, 1'b0));
		directed_rows.push_back(q_row(32'hFFFF, 32'h0, 32'hFFFF, 1'b0));
		directed_rows.push_back(q_row(32'h1, 32'h0, 32'hFFFF, 1'b0));
		directed_rows.push_back(q_row(32'hFFFF, 32'h0, 32'h1, 1'b0));
		for (r = 0; r < directed_rows.size(); r++)
			issue(directed_rows[r].b, directed_rows[r].fixed, directed_rows[r].want);
		drain();

		// Random phases over a spread of terrain settings, extremes first.
		for (p = 0; p < 10; p++) begin
			case (p)
				0: program_terrain(64, 64, 32'h10000, 32'h10000, 0, 0, 0);
				1: program_terrain(1, 1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
					32'h7FFFFFFF, 32'h80000000);
				2: program_terrain(3, 5, 32'h1, 32'h3, 32'h7FFFFF00, 32'h80000000,
					32'hFFFFFF9C);
				3: program_terrain(0, 4, 32'h10000, 32'h10000, 0, 0, 0);
				4: program_terrain(100, 127, 32'h20000, 32'h18000, 32'hFFF00000,
					32'h00010000, 32'h00100000);
				5: program_terrain(4, 4, 32'h0, 32'h10000, 0, 0, 0);
				default: program_terrain($urandom_range(1, 64), $urandom_range(1, 64),
					$urandom_range(1, 32'h80000), $urandom_range(1, 32'h80000),
					$urandom, $urandom, $urandom);
			endcase
			calm = (p == 6);
			if (p == 0)
				hold_req = 1'b1;
			random_phase((p == 3 || p == 5) ? 25 : 60);
			drain();
		end

		in_valid <= 1'b0;
		while (height_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
